FILE: sv/gwds_pkg.sv
// ----------------------------------------------------------------------------
// gwds_pkg
// Shared types, widths, request codes and register map of the glow winner
// debounce selector.
// ----------------------------------------------------------------------------
package gwds_pkg;

    localparam int SLOT_COUNT = 3;
    localparam int SLOT_W     = 2;
    localparam int LEVEL_W    = 12;
    localparam int CNT_W      = 8;
    localparam int REQ_W      = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam int S_TDATA_W = ((SLOT_COUNT * LEVEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_OBSERVE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CONFIRM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_MARK    = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LEAD_MARGIN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_LEVEL     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STABLE_NEEDED = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRACE_COUNT   = 2'd3;

    // register reset values
    localparam logic [LEVEL_W-1:0] RST_LEAD_MARGIN   = 12'd480;
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL     = 12'd1280;
    localparam logic [CNT_W-1:0]   RST_STABLE_NEEDED = 8'd3;
    localparam logic [CNT_W-1:0]   RST_GRACE_COUNT   = 8'd5;

    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] lead_margin;
        logic [LEVEL_W-1:0] min_level;
        logic [CNT_W-1:0]   stable_needed;
        logic [CNT_W-1:0]   grace_count;
    } cfg_t;

    typedef struct packed {
        logic              glowing;
        logic [SLOT_W-1:0] slot;
    } win_t;

    typedef struct packed {
        logic              cand_valid;
        logic [SLOT_W-1:0] cand_slot;
        logic [CNT_W-1:0]  cand_frames;
        logic              latch_valid;
        logic [SLOT_W-1:0] latch_slot;
        logic [CNT_W-1:0]  grace_left;
        logic              done;
    } state_t;

    typedef struct packed {
        logic              pick_valid;
        logic [SLOT_W-1:0] pick_slot;
        logic              done_flag;
    } result_t;

endpackage

FILE: sv/gwds_winner.sv
// ----------------------------------------------------------------------------
// gwds_winner
// Finds the brightest slot (lowest index on ties) and the runner-up, and
// decides whether the frame is glowing.
// ----------------------------------------------------------------------------
module gwds_winner
    import gwds_pkg::*;
(
    input  level_t levels [SLOT_COUNT],
    input  cfg_t   cfg,
    output win_t   win
);

    logic [SLOT_W-1:0]  win_idx;
    level_t             win_lvl;
    level_t             second;
    logic [LEVEL_W-1:0] margin;

    always_comb begin
        win_idx = '0;
        win_lvl = levels[0];
        for (int i = 1; i < SLOT_COUNT; i++) begin
            if (levels[i] > win_lvl) begin
                win_idx = SLOT_W'(i);
                win_lvl = levels[i];
            end
        end
        second = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (SLOT_W'(i) != win_idx && levels[i] > second) begin
                second = levels[i];
            end
        end
        // zero margin behaves as one
        margin = (cfg.lead_margin == '0) ? LEVEL_W'(1) : cfg.lead_margin;
        win.slot    = win_idx;
        win.glowing = (win_lvl >= cfg.min_level) && ((win_lvl - second) >= margin);
    end

endmodule

FILE: sv/gwds_state.sv
// ----------------------------------------------------------------------------
// gwds_state
// Candidate, latch and freeze state with its per-request update and the
// result of each request.
// ----------------------------------------------------------------------------
module gwds_state
    import gwds_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [REQ_W-1:0] req,
    input  win_t             win,
    input  cfg_t             cfg,
    output result_t          res
);

    state_t           st_reg;
    state_t           st_next;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] grace;
    logic [CNT_W:0]   frames_inc;

    always_comb begin
        need       = (cfg.stable_needed == '0) ? CNT_W'(1) : cfg.stable_needed;
        grace      = (cfg.grace_count == '0) ? CNT_W'(1) : cfg.grace_count;
        frames_inc = {1'b0, st_reg.cand_frames} + (CNT_W+1)'(1);
        st_next    = st_reg;
        res        = '0;
        unique case (req)
            REQ_OBSERVE: begin
                if (!st_reg.done) begin
                    if (win.glowing) begin
                        if (st_reg.cand_valid && st_reg.cand_slot == win.slot) begin
                            // saturate at the needed count
                            st_next.cand_frames = (frames_inc < {1'b0, need}) ?
                                                  frames_inc[CNT_W-1:0] : need;
                        end else begin
                            st_next.cand_valid  = 1'b1;
                            st_next.cand_slot   = win.slot;
                            st_next.cand_frames = CNT_W'(1);
                        end
                        if (st_next.cand_frames >= need) begin
                            st_next.latch_valid = 1'b1;
                            st_next.latch_slot  = win.slot;
                            st_next.grace_left  = grace;
                        end
                    end else begin
                        st_next.cand_valid  = 1'b0;
                        st_next.cand_slot   = '0;
                        st_next.cand_frames = '0;
                        if (st_reg.latch_valid && st_reg.grace_left != '0) begin
                            st_next.grace_left = st_reg.grace_left - CNT_W'(1);
                            if (st_reg.grace_left == CNT_W'(1)) begin
                                st_next.latch_valid = 1'b0;
                                st_next.latch_slot  = '0;
                            end
                        end
                    end
                end
            end
            REQ_CONFIRM: begin
                if (!st_reg.done && st_reg.latch_valid) begin
                    st_next.done  = 1'b1;
                    res.pick_valid = 1'b1;
                    res.pick_slot  = st_reg.latch_slot;
                end
            end
            REQ_RESET: begin
                st_next = '0;
            end
            REQ_MARK: begin
                st_next.done = 1'b1;
            end
            default: begin
                st_next = st_reg;
            end
        endcase
        res.done_flag = st_next.done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (en) begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: sv/glow_winner_debounce_selector_top.sv
// ----------------------------------------------------------------------------
// glow_winner_debounce_selector_top
// Picks the glowing slot of a stream of brightness frames with debounce,
// grace hold and a one-shot confirm.
// ----------------------------------------------------------------------------
// One request per clock cycle, sustained while the output stream is ready. Each
// request is registered at the input, then the winner compare and the state
// update are combinational and the result lands in the output register:
// m_tvalid rises when that register is loaded, which is held back while a
// stalled result waits in it. The state update of one request is registered
// and feeds the next request, which sets the one-request-per-cycle figure.
// Every request gives exactly one result. Registers are written through
// cfg_wr_en, cfg_addr and cfg_wr_data; the user must do so only while the block is idle, the block does not enforce it.
module glow_winner_debounce_selector_top
    import gwds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // level_0, level_1, level_2, zero fill
    input  logic [REQ_W-1:0]      s_tuser,   // req_type
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // pick_valid, pick_slot, done_flag, zero fill
);

    cfg_t             cfg_reg;
    logic             in_valid_reg;
    logic [REQ_W-1:0] in_req_reg;
    level_t           in_level_reg [SLOT_COUNT];
    logic             out_valid_reg;
    result_t          out_res_reg;
    logic             advance;
    win_t             win;
    result_t          res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lead_margin   <= RST_LEAD_MARGIN;
            cfg_reg.min_level     <= RST_MIN_LEVEL;
            cfg_reg.stable_needed <= RST_STABLE_NEEDED;
            cfg_reg.grace_count   <= RST_GRACE_COUNT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_LEAD_MARGIN:   cfg_reg.lead_margin   <= cfg_wr_data[LEVEL_W-1:0];
                CFG_MIN_LEVEL:     cfg_reg.min_level     <= cfg_wr_data[LEVEL_W-1:0];
                CFG_STABLE_NEEDED: cfg_reg.stable_needed <= cfg_wr_data[CNT_W-1:0];
                CFG_GRACE_COUNT:   cfg_reg.grace_count   <= cfg_wr_data[CNT_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // request moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg <= s_tuser;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                in_level_reg[i] <= s_tdata[i*LEVEL_W +: LEVEL_W];
            end
        end
    end

    gwds_winner u_winner (
        .levels (in_level_reg),
        .cfg    (cfg_reg),
        .win    (win)
    );

    gwds_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .req     (in_req_reg),
        .win     (win),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-SLOT_W-2)'(0), out_res_reg.done_flag,
                       out_res_reg.pick_slot, out_res_reg.pick_valid};

endmodule

FILE: sv/gwds_checker.sv
// ----------------------------------------------------------------------------
// gwds_checker
// Port-level checks of the result stream of the glow winner debounce
// selector, bound to the top level.
// ----------------------------------------------------------------------------
module gwds_checker
    import gwds_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a pick always freezes the block
    a_pick_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tdata[SLOT_W+1])
        else $error("pick returned without done flag");

    // no slot reported without a pick
    a_slot_zero_no_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[SLOT_W:1] == '0))
        else $error("slot nonzero without pick");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[SLOT_W:1] < SLOT_W'(SLOT_COUNT)))
        else $error("picked slot out of range");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind glow_winner_debounce_selector_top gwds_checker u_gwds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/tb_glow_winner_debounce_selector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glow_winner_debounce_selector_top
// Self-checking bench for the glow winner debounce selector: every accepted
// request is run through a local predictor of the winner search, debounce,
// grace hold and confirm logic, and each result on the output stream is
// compared field by field with the oldest prediction. Directed cases come
// first, then phases of random request sequences under changing registers,
// with random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_glow_winner_debounce_selector_top;
    import gwds_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 140;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;  // level_0, level_1, level_2, zero fill
    logic [REQ_W-1:0]      s_tuser     = '0;  // req_type
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // pick_valid, pick_slot, done_flag, zero fill

    glow_winner_debounce_selector_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // predictor copy of the registers and the selector state
    cfg_t    sel_cfg;
    state_t  sel_state;
    result_t pick_queue[$];

    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  rx_hold_left  = 0;
    bit  idle_on       = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic level_t rand_level();
        return level_t'($urandom_range(4095));
    endfunction

    function automatic result_t predict_pick(input logic [REQ_W-1:0] req,
                                             input level_t [SLOT_COUNT-1:0] lv);
        result_t res;
        int      winner;
        int      runner_up;
        int      need;
        int      margin;
        bit      have_runner;
        bit      glowing;
        res         = '0;
        winner      = 0;
        runner_up   = 0;
        have_runner = 1'b0;
        need        = at_least_one(int'(sel_cfg.stable_needed));
        margin      = at_least_one(int'(sel_cfg.lead_margin));
        case (req)
            REQ_OBSERVE: begin
                if (!sel_state.done) begin
                    for (int i = 1; i < SLOT_COUNT; i++) begin
                        if (lv[i] > lv[winner]) winner = i;
                    end
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (i != winner && (!have_runner || int'(lv[i]) > runner_up)) begin
                            runner_up   = int'(lv[i]);
                            have_runner = 1'b1;
                        end
                    end
                    glowing = (lv[winner] >= sel_cfg.min_level) &&
                              (int'(lv[winner]) - runner_up >= margin);
                    if (glowing) begin
                        if (sel_state.cand_valid && int'(sel_state.cand_slot) == winner) begin
                            if (int'(sel_state.cand_frames) + 1 < need)
                                sel_state.cand_frames = sel_state.cand_frames + 1'b1;
                            else
                                sel_state.cand_frames = CNT_W'(need);
                        end else begin
                            sel_state.cand_valid  = 1'b1;
                            sel_state.cand_slot   = SLOT_W'(winner);
                            sel_state.cand_frames = CNT_W'(1);
                        end
                        if (int'(sel_state.cand_frames) >= need) begin
                            sel_state.latch_valid = 1'b1;
                            sel_state.latch_slot  = SLOT_W'(winner);
                            sel_state.grace_left  =
                                CNT_W'(at_least_one(int'(sel_cfg.grace_count)));
                        end
                    end else begin
                        sel_state.cand_valid  = 1'b0;
                        sel_state.cand_slot   = '0;
                        sel_state.cand_frames = '0;
                        if (sel_state.latch_valid && sel_state.grace_left != 0) begin
                            sel_state.grace_left = sel_state.grace_left - 1'b1;
                            if (sel_state.grace_left == 0) begin
                                sel_state.latch_valid = 1'b0;
                                sel_state.latch_slot  = '0;
                            end
                        end
                    end
                end
            end
            REQ_CONFIRM: begin
                if (!sel_state.done && sel_state.latch_valid) begin
                    sel_state.done = 1'b1;
                    res.pick_valid = 1'b1;
                    res.pick_slot  = sel_state.latch_slot;
                end
            end
            REQ_RESET: sel_state = '0;
            default:   sel_state.done = 1'b1;
        endcase
        res.done_flag = sel_state.done;
        return res;
    endfunction

    // one request on the input stream; returns in the time step of acceptance
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input level_t l0, input level_t l1, input level_t l2);
        level_t [SLOT_COUNT-1:0] lv;
        lv = {l2, l1, l0};
        if (idle_on && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'(lv);
        do @(posedge aclk); while (!s_tready);
        pick_queue.push_back(predict_pick(req, lv));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pick_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (addr)
            CFG_LEAD_MARGIN:   sel_cfg.lead_margin   = data[LEVEL_W-1:0];
            CFG_MIN_LEVEL:     sel_cfg.min_level     = data[LEVEL_W-1:0];
            CFG_STABLE_NEEDED: sel_cfg.stable_needed = data[CNT_W-1:0];
            default:           sel_cfg.grace_count   = data[CNT_W-1:0];
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] lead,
                              input logic [CFG_DATA_W-1:0] min_lvl,
                              input logic [CFG_DATA_W-1:0] stable,
                              input logic [CFG_DATA_W-1:0] grace);
        wait_drain();
        write_reg(CFG_LEAD_MARGIN, lead);
        write_reg(CFG_MIN_LEVEL, min_lvl);
        write_reg(CFG_STABLE_NEEDED, stable);
        write_reg(CFG_GRACE_COUNT, grace);
    endtask

    // observe frame in which the given slot glows under the current registers
    task automatic send_glow(input int slot);
        level_t [SLOT_COUNT-1:0] lv;
        int margin;
        int floor_lvl;
        int top;
        margin    = at_least_one(int'(sel_cfg.lead_margin));
        floor_lvl = (int'(sel_cfg.min_level) > margin) ? int'(sel_cfg.min_level) : margin;
        top       = $urandom_range(4095, floor_lvl);
        for (int i = 0; i < SLOT_COUNT; i++)
            lv[i] = (i == slot) ? level_t'(top) : level_t'($urandom_range(top - margin, 0));
        send_request(REQ_OBSERVE, lv[0], lv[1], lv[2]);
    endtask

    task automatic send_random_requests(input int count);
        int sent;
        int pick;
        int len;
        int run_max;
        int slot;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                run_max = at_least_one(int'(sel_cfg.stable_needed)) + 2;
                if (run_max > 12) run_max = 12;
                len  = $urandom_range(run_max, 1);
                slot = $urandom_range(SLOT_COUNT - 1);
                repeat (len) send_glow(slot);
                sent += len;
            end else if (pick < 70) begin
                len = $urandom_range(at_least_one(int'(sel_cfg.grace_count)) + 1, 1);
                if (len > 8) len = 8;
                repeat (len) send_request(REQ_OBSERVE, rand_level(), rand_level(),
                                          rand_level());
                sent += len;
            end else if (pick < 82) begin
                send_request(REQ_CONFIRM, rand_level(), rand_level(), rand_level());
                sent++;
            end else if (pick < 88) begin
                send_request(REQ_RESET, rand_level(), rand_level(), rand_level());
                sent++;
            end else if (pick < 92) begin
                send_request(REQ_MARK, rand_level(), rand_level(), rand_level());
                sent++;
            end else begin
                send_request(REQ_W'($urandom_range(3)), rand_level(), rand_level(),
                             rand_level());
                sent++;
            end
        end
    endtask

    // reset values: slot 1 latches after three frames, confirm freezes the block
    task automatic test_default_latch();
        repeat (3) send_request(REQ_OBSERVE, 12'd0, 12'd2000, 12'd100);
        send_request(REQ_CONFIRM, 12'd0, 12'd0, 12'd0);
        send_request(REQ_OBSERVE, 12'd0, 12'd0, 12'd4095);
        send_request(REQ_CONFIRM, 12'd0, 12'd0, 12'd0);
        send_request(REQ_RESET, 12'd4095, 12'd4095, 12'd4095);
    endtask

    task automatic test_extreme_levels();
        send_request(REQ_OBSERVE, 12'd0, 12'd0, 12'd0);
        send_request(REQ_OBSERVE, 12'd4095, 12'd4095, 12'd4095);
        send_request(REQ_OBSERVE, 12'd4095, 12'd0, 12'd0);
        send_request(REQ_OBSERVE, 12'd0, 12'd0, 12'd4095);
        // tie between upper slots goes to the lower index, lead is zero
        send_request(REQ_OBSERVE, 12'd0, 12'd4095, 12'd4095);
        send_request(REQ_CONFIRM, 12'd4095, 12'd4095, 12'd4095);
        send_request(REQ_MARK, 12'd0, 12'd0, 12'd0);
        send_request(REQ_CONFIRM, 12'd0, 12'd0, 12'd0);
        send_request(REQ_RESET, 12'd0, 12'd0, 12'd0);
    endtask

    // zero lead, stable and grace act as one
    task automatic test_zero_registers();
        set_config(12'd0, 12'd0, 12'd0, 12'd0);
        send_request(REQ_OBSERVE, 12'd5, 12'd6, 12'd6);
        send_request(REQ_OBSERVE, 12'd5, 12'd6, 12'd5);
        send_request(REQ_OBSERVE, 12'd0, 12'd0, 12'd0);
        send_request(REQ_CONFIRM, 12'd0, 12'd0, 12'd0);
    endtask

    // counter saturates, latch survives dim frames within grace
    task automatic test_grace_hold();
        set_config(12'd16, 12'd100, 12'd2, 12'd3);
        repeat (3) send_request(REQ_OBSERVE, 12'd10, 12'd20, 12'd300);
        repeat (2) send_request(REQ_OBSERVE, 12'd50, 12'd50, 12'd50);
        send_request(REQ_CONFIRM, 12'd0, 12'd0, 12'd0);
        send_request(REQ_RESET, 12'd0, 12'd0, 12'd0);
    endtask

    // output held off while the input keeps offering requests back to back
    task automatic test_backpressure();
        set_config(12'd480, 12'd1280, 12'd3, 12'd5);
        idle_on      = 1'b0;
        rx_hold_left = 300;
        send_random_requests(40);
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_phases();
        set_config(CFG_DATA_W'($urandom_range(600, 1)), CFG_DATA_W'($urandom_range(2000)),
                   CFG_DATA_W'($urandom_range(4, 1)), CFG_DATA_W'($urandom_range(6, 1)));
        send_random_requests(RANDOM_ITEMS);
        set_config(12'd1, 12'd0, 12'd1, 12'd1);
        idle_on = 1'b0;
        send_random_requests(RANDOM_ITEMS);
        idle_on = 1'b1;
        set_config(12'd4095, 12'd4095, 12'd255, 12'd255);
        send_random_requests(RANDOM_ITEMS);
        // upper data bits above the 8-bit counters are dropped
        set_config(12'd0, CFG_DATA_W'($urandom_range(4095)), 12'hf00, 12'h700);
        send_random_requests(RANDOM_ITEMS);
        set_config(CFG_DATA_W'($urandom_range(300, 1)), CFG_DATA_W'($urandom_range(1500)),
                   CFG_DATA_W'($urandom_range(5, 1)), CFG_DATA_W'($urandom_range(8, 1)));
        send_random_requests(RANDOM_ITEMS);
        set_config(CFG_DATA_W'($urandom_range(4095)), CFG_DATA_W'($urandom_range(4095)),
                   CFG_DATA_W'($urandom_range(4095)), CFG_DATA_W'($urandom_range(4095)));
        send_random_requests(RANDOM_ITEMS);
    endtask

    // output side ready pattern
    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (rx_hold_left > 0) begin
                m_tready     <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else if (!idle_on) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 31);
            end
        end
    end

    // result checker
    initial begin
        result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pick_queue.size() == 0) begin
                    $error("result with no request pending, m_tdata %0h", m_tdata);
                    fail_count++;
                end else begin
                    want = pick_queue.pop_front();
                    if (m_tdata[0] !== want.pick_valid) begin
                        $error("pick_valid expected %0d got %0d", want.pick_valid, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[2:1] !== want.pick_slot) begin
                        $error("pick_slot expected %0d got %0d", want.pick_slot, m_tdata[2:1]);
                        fail_count++;
                    end
                    if (m_tdata[3] !== want.done_flag) begin
                        $error("done_flag expected %0d got %0d", want.done_flag, m_tdata[3]);
                        fail_count++;
                    end
                    if (m_tdata[M_TDATA_W-1:4] !== '0) begin
                        $error("m_tdata fill expected 0 got %0h", m_tdata[M_TDATA_W-1:4]);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        sel_cfg   = '{RST_LEAD_MARGIN, RST_MIN_LEVEL, RST_STABLE_NEEDED, RST_GRACE_COUNT};
        sel_state = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_default_latch();
        test_extreme_levels();
        test_zero_registers();
        test_grace_hold();
        test_backpressure();
        test_random_phases();
        wait_drain();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
